// ===== rtl/core/fpp_pkg.sv =====
package fpp_pkg;

  // Character codes used by the parser.
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_ONE   = "1";
  localparam logic [7:0] CH_EIGHT = "8";
  localparam logic [7:0] CH_NINE  = "9";
  localparam logic [7:0] CH_WHITE = "w";
  localparam logic [7:0] CH_BLACK = "b";
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_DASH  = "-";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_FILE_A = "a";
  localparam logic [7:0] CH_FILE_H = "h";
  localparam logic [7:0] CH_WK = "K";
  localparam logic [7:0] CH_WQ = "Q";
  localparam logic [7:0] CH_BK = "k";
  localparam logic [7:0] CH_BQ = "q";

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // Parser phases.
  localparam logic [2:0] PH_PLACE  = 3'd0;
  localparam logic [2:0] PH_SIDE   = 3'd1;
  localparam logic [2:0] PH_SIDESP = 3'd2;
  localparam logic [2:0] PH_CASTLE = 3'd3;
  localparam logic [2:0] PH_EP     = 3'd4;
  localparam logic [2:0] PH_HALF   = 3'd5;
  localparam logic [2:0] PH_MOVE   = 3'd6;
  localparam logic [2:0] PH_SKIP   = 3'd7;

  // Result kinds.
  localparam logic [1:0] KIND_PLACE = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Castling right bit positions.
  localparam int CR_WK = 0;
  localparam int CR_WQ = 1;
  localparam int CR_BK = 2;
  localparam int CR_BQ = 3;

  localparam logic [3:0] FILES_FULL = 4'd8;

  typedef struct packed {
    logic       hit;
    logic [3:0] code;
  } piece_dec_t;

  // Maps a piece letter to its code; hit is low for any other character.
  function automatic piece_dec_t piece_decode(input logic [7:0] c);
    piece_dec_t d;
    d.hit = 1'b1;
    d.code = 4'd0;
    case (c)
      "P": d.code = 4'd0;
      "N": d.code = 4'd1;
      "B": d.code = 4'd2;
      "R": d.code = 4'd3;
      "Q": d.code = 4'd4;
      "K": d.code = 4'd5;
      "p": d.code = 4'd6;
      "n": d.code = 4'd7;
      "b": d.code = 4'd8;
      "r": d.code = 4'd9;
      "q": d.code = 4'd10;
      "k": d.code = 4'd11;
      default: d.hit = 1'b0;
    endcase
    return d;
  endfunction

  // value * 10 + digit, saturating at the 16-bit maximum.
  function automatic logic [15:0] add_digit(input logic [15:0] v, input logic [3:0] d);
    logic [19:0] n;
    n = 20'({v, 3'b000}) + 20'({v, 1'b0}) + 20'(d);
    return (n > 20'(CNT_MAX)) ? CNT_MAX : n[15:0];
  endfunction

endpackage

// ===== rtl/core/fen_position_parser.sv =====
// A result appears in the output register in the cycle after the transfer of
// the character that causes it.
// Throughput: one character per cycle; the only thing that holds the input back is
// a result waiting in the output register while out_stall is high.
// Reset: synchronous, active low rst_n; the parser returns to the piece placement
// field at rank 8, file a, with all flags and counters cleared and no result held.
module fen_position_parser
  import fpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  input  logic        in_end_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_piece,
  output logic [5:0]  out_square,
  output logic        out_white_to_move,
  output logic [3:0]  out_castle_rights,
  output logic        out_ep_valid,
  output logic [5:0]  out_ep_square,
  output logic [15:0] out_halfmove_clock,
  output logic [15:0] out_move_number
);

  // Parser state. Every field is updated only on an input transfer.
  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  file_pos_r, file_pos_nxt;
  logic [2:0]  rank_pos_r, rank_pos_nxt;
  logic        side_flag_r, side_flag_nxt;
  logic [3:0]  castle_bits_r, castle_bits_nxt;
  logic        ep_flag_r, ep_flag_nxt;
  logic [5:0]  ep_sq_r, ep_sq_nxt;
  logic [15:0] half_count_r, half_count_nxt;
  logic [15:0] move_count_r, move_count_nxt;
  logic        digits_seen_r, digits_seen_nxt;

  // Result register. It decouples the two channels so that a new character can be
  // taken in the same cycle as the held result is transferred out.
  logic        out_valid_r;
  logic [1:0]  kind_r, kind_nxt;
  logic [3:0]  piece_r, piece_nxt;
  logic [5:0]  square_r, square_nxt;
  logic        wtm_r, wtm_nxt;
  logic [3:0]  castle_r, castle_nxt;
  logic        epv_r, epv_nxt;
  logic [5:0]  eps_r, eps_nxt;
  logic [15:0] half_r, half_nxt;
  logic [15:0] move_r, move_nxt;
  logic        res_valid;

  logic        in_xfer;
  piece_dec_t  pdec;
  logic        err;
  logic        place;
  logic [4:0]  new_file;
  logic [15:0] cnt_sel;
  logic [15:0] cnt_upd;

  // The input waits only while a finished result is held and the consumer stalls.
  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  always_comb begin
    phase_nxt       = phase_r;
    file_pos_nxt    = file_pos_r;
    rank_pos_nxt    = rank_pos_r;
    side_flag_nxt   = side_flag_r;
    castle_bits_nxt = castle_bits_r;
    ep_flag_nxt     = ep_flag_r;
    ep_sq_nxt       = ep_sq_r;
    half_count_nxt  = half_count_r;
    move_count_nxt  = move_count_r;
    digits_seen_nxt = digits_seen_r;
    err   = 1'b0;
    place = 1'b0;
    pdec  = piece_decode(in_char_in);
    new_file = {1'b0, file_pos_r} + {1'b0, in_char_in[3:0]};

    // One shared multiply-by-ten unit serves whichever counter is being read.
    cnt_sel = (phase_r == PH_HALF) ? half_count_r : move_count_r;
    cnt_upd = add_digit(cnt_sel, in_char_in[3:0]);

    kind_nxt   = KIND_PLACE;
    piece_nxt  = 4'd0;
    square_nxt = 6'd0;
    wtm_nxt    = 1'b0;
    castle_nxt = 4'd0;
    epv_nxt    = 1'b0;
    eps_nxt    = 6'd0;
    half_nxt   = 16'd0;
    move_nxt   = 16'd0;
    res_valid  = 1'b0;

    case (phase_r)
      PH_PLACE: begin
        if (pdec.hit) begin
          // A piece on a rank whose eight files are already filled is an error.
          if (file_pos_r[3]) begin
            err = 1'b1;
          end else begin
            place        = 1'b1;
            piece_nxt    = pdec.code;
            square_nxt   = {rank_pos_r, file_pos_r[2:0]};
            file_pos_nxt = file_pos_r + 4'd1;
          end
        end else if (in_char_in inside {[CH_ONE:CH_EIGHT]}) begin
          if (new_file > 5'(FILES_FULL)) begin
            err = 1'b1;
          end else begin
            file_pos_nxt = new_file[3:0];
          end
        end else if (in_char_in == CH_SLASH) begin
          if (file_pos_r != FILES_FULL || rank_pos_r == 3'd0) begin
            err = 1'b1;
          end else begin
            rank_pos_nxt = rank_pos_r - 3'd1;
            file_pos_nxt = 4'd0;
          end
        end else if (in_char_in == CH_SPACE && file_pos_r == FILES_FULL &&
                     rank_pos_r == 3'd0) begin
          phase_nxt = PH_SIDE;
        end else begin
          err = 1'b1;
        end
      end
      PH_SIDE: begin
        if (in_char_in == CH_WHITE) begin
          side_flag_nxt = 1'b1;
          phase_nxt     = PH_SIDESP;
        end else if (in_char_in == CH_BLACK) begin
          side_flag_nxt = 1'b0;
          phase_nxt     = PH_SIDESP;
        end else begin
          err = 1'b1;
        end
      end
      PH_SIDESP: begin
        if (in_char_in == CH_SPACE) begin
          phase_nxt       = PH_CASTLE;
          digits_seen_nxt = 1'b0;
        end else begin
          err = 1'b1;
        end
      end
      PH_CASTLE: begin
        // Here digits_seen means at least one castling character was given.
        if (in_char_in == CH_SPACE) begin
          if (!digits_seen_r) begin
            err = 1'b1;
          end else begin
            phase_nxt       = PH_EP;
            digits_seen_nxt = 1'b0;
            ep_flag_nxt     = 1'b0;
          end
        end else if (in_char_in == CH_WK) begin
          castle_bits_nxt[CR_WK] = 1'b1;
          digits_seen_nxt = 1'b1;
        end else if (in_char_in == CH_WQ) begin
          castle_bits_nxt[CR_WQ] = 1'b1;
          digits_seen_nxt = 1'b1;
        end else if (in_char_in == CH_BK) begin
          castle_bits_nxt[CR_BK] = 1'b1;
          digits_seen_nxt = 1'b1;
        end else if (in_char_in == CH_BQ) begin
          castle_bits_nxt[CR_BQ] = 1'b1;
          digits_seen_nxt = 1'b1;
        end else if (in_char_in == CH_DASH) begin
          digits_seen_nxt = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      PH_EP: begin
        // digits_seen marks a complete field; only the closing space may follow.
        if (digits_seen_r) begin
          if (in_char_in == CH_SPACE) begin
            phase_nxt       = PH_HALF;
            digits_seen_nxt = 1'b0;
          end else begin
            err = 1'b1;
          end
        end else if (!ep_flag_r) begin
          if (in_char_in == CH_DASH) begin
            digits_seen_nxt = 1'b1;
          end else if (in_char_in inside {[CH_FILE_A:CH_FILE_H]}) begin
            ep_sq_nxt   = {3'd0, in_char_in[2:0] - 3'd1};
            ep_flag_nxt = 1'b1;
          end else begin
            err = 1'b1;
          end
        end else if (in_char_in inside {[CH_ONE:CH_EIGHT]}) begin
          ep_sq_nxt       = {in_char_in[2:0] - 3'd1, ep_sq_r[2:0]};
          digits_seen_nxt = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      PH_HALF: begin
        if (in_char_in inside {[CH_ZERO:CH_NINE]}) begin
          half_count_nxt  = cnt_upd;
          digits_seen_nxt = 1'b1;
        end else if (in_char_in == CH_SPACE && digits_seen_r) begin
          phase_nxt       = PH_MOVE;
          digits_seen_nxt = 1'b0;
        end else begin
          err = 1'b1;
        end
      end
      PH_MOVE: begin
        if (in_char_in inside {[CH_ZERO:CH_NINE]}) begin
          move_count_nxt  = cnt_upd;
          digits_seen_nxt = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        // Skipping the rest of a string that already produced an error.
      end
    endcase

    // Result selection: nothing while skipping, then error, then the end of the
    // string (summary or error), then a piece placement.
    if (phase_r == PH_SKIP) begin
      res_valid = 1'b0;
    end else if (err) begin
      res_valid = 1'b1;
      kind_nxt  = KIND_ERROR;
      phase_nxt = PH_SKIP;
    end else if (in_end_of_string) begin
      res_valid  = 1'b1;
      piece_nxt  = 4'd0;
      square_nxt = 6'd0;
      if (phase_nxt == PH_MOVE && digits_seen_nxt) begin
        kind_nxt   = KIND_SUMMARY;
        wtm_nxt    = side_flag_nxt;
        castle_nxt = castle_bits_nxt;
        epv_nxt    = ep_flag_nxt;
        eps_nxt    = ep_flag_nxt ? ep_sq_nxt : 6'd0;
        half_nxt   = half_count_nxt;
        move_nxt   = move_count_nxt;
      end else begin
        kind_nxt = KIND_ERROR;
      end
    end else if (place) begin
      res_valid = 1'b1;
      kind_nxt  = KIND_PLACE;
    end

    if (kind_nxt == KIND_ERROR) begin
      piece_nxt  = 4'd0;
      square_nxt = 6'd0;
    end

    // The final character returns the parser to its starting state.
    if (in_end_of_string) begin
      phase_nxt       = PH_PLACE;
      file_pos_nxt    = 4'd0;
      rank_pos_nxt    = 3'd7;
      side_flag_nxt   = 1'b0;
      castle_bits_nxt = 4'd0;
      ep_flag_nxt     = 1'b0;
      ep_sq_nxt       = 6'd0;
      half_count_nxt  = 16'd0;
      move_count_nxt  = 16'd0;
      digits_seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_PLACE;
      file_pos_r    <= 4'd0;
      rank_pos_r    <= 3'd7;
      side_flag_r   <= 1'b0;
      castle_bits_r <= 4'd0;
      ep_flag_r     <= 1'b0;
      ep_sq_r       <= 6'd0;
      half_count_r  <= 16'd0;
      move_count_r  <= 16'd0;
      digits_seen_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_r       <= phase_nxt;
        file_pos_r    <= file_pos_nxt;
        rank_pos_r    <= rank_pos_nxt;
        side_flag_r   <= side_flag_nxt;
        castle_bits_r <= castle_bits_nxt;
        ep_flag_r     <= ep_flag_nxt;
        ep_sq_r       <= ep_sq_nxt;
        half_count_r  <= half_count_nxt;
        move_count_r  <= move_count_nxt;
        digits_seen_r <= digits_seen_nxt;
        // A transfer in implies any held result is being taken this cycle.
        out_valid_r   <= res_valid;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload carries no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (in_xfer && res_valid) begin
      kind_r   <= kind_nxt;
      piece_r  <= piece_nxt;
      square_r <= square_nxt;
      wtm_r    <= wtm_nxt;
      castle_r <= castle_nxt;
      epv_r    <= epv_nxt;
      eps_r    <= eps_nxt;
      half_r   <= half_nxt;
      move_r   <= move_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_piece          = piece_r;
  assign out_square         = square_r;
  assign out_white_to_move  = wtm_r;
  assign out_castle_rights  = castle_r;
  assign out_ep_valid       = epv_r;
  assign out_ep_square      = eps_r;
  assign out_halfmove_clock = half_r;
  assign out_move_number    = move_r;

endmodule
